// ===== hw/rtl/booth_pkg.sv =====
// Shared widths and reset constants for the radix-2 Booth multiplier.
package booth_pkg;

  localparam int unsigned IN_W  = 8;   // multiplicand / multiplier port width
  localparam int unsigned OUT_W = 16;  // product port width
  localparam int unsigned CFG_W = 4;   // operand_bits register width

  localparam logic [CFG_W-1:0] CfgReset = 4'd8;
  localparam int unsigned      MinBits  = 2;

endpackage

// ===== hw/rtl/booth_radix2_multiplier.sv =====
// Top level of the radix-2 Booth signed multiplier: cell chain and output register.
//
// Signed two's-complement multiplier built as a chain of MAX_BITS Booth cells,
// one recoding step per cell, followed by an output register. A new operand
// word is taken every cycle while the output side keeps up; from acceptance
// to product valid a word passes through the register of each cell in order
// and then the output register. Every cell has its own valid bit and
// takes a word whenever it is empty or its neighbor takes its content, so a
// stall on the output fills bubbles before it reaches the input. The
// operand_bits register (reset 8, clamped to 2..MAX_BITS) sets the operand
// width n: inputs are sign-extended or truncated to MAX_BITS and masked to n
// bits, cells past step n pass data through, and the product A:Q of 2n bits is
// sign-extended or truncated to 16 bits. The accumulator is n bits wide and
// wraps, so the most negative multiplicand behaves as in the classic n-bit
// Booth register. Write operand_bits only while no word is in flight.
module booth_radix2_multiplier
  import booth_pkg::*;
#(
  parameter int unsigned MAX_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [IN_W-1:0]  multiplicand_i,
  input  logic signed [IN_W-1:0]  multiplier_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] product_o
);

  localparam int unsigned W  = MAX_BITS;
  localparam int unsigned NW = $clog2(MAX_BITS + 1);

  // operand_bits register
  logic [CFG_W-1:0] cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // effective width, clamped to the supported range
  logic [NW-1:0] n;
  logic [W-1:0]  mask, top;

  always_comb begin
    if (int'(cfg_q) < int'(MinBits)) begin
      n = NW'(MinBits);
    end else if (int'(cfg_q) > int'(MAX_BITS)) begin
      n = NW'(MAX_BITS);
    end else begin
      n = NW'(cfg_q);
    end
  end

  assign mask = (W'(1) << n) - W'(1);
  assign top  = W'(1) << (n - NW'(1));

  // operands into the chain, reduced to n bits
  logic signed [W-1:0] m_ext, q_ext;

  assign m_ext = W'(multiplicand_i);
  assign q_ext = W'(multiplier_i);

  // chain links: index k feeds cell k, index W leaves the last cell
  logic         valid_c [W+1];
  logic         ready_c [W+1];
  logic [W-1:0] a_c     [W+1];
  logic [W-1:0] q_c     [W+1];
  logic         qp_c    [W+1];
  logic [W-1:0] m_c     [W+1];

  assign valid_c[0] = in_valid_i;
  assign a_c[0]     = '0;
  assign q_c[0]     = q_ext & mask;
  assign qp_c[0]    = 1'b0;
  assign m_c[0]     = m_ext & mask;
  assign in_stall_o = !ready_c[0];

  for (genvar k = 0; k < W; k++) begin : g_cell
    booth_cell #(
      .W   (W),
      .NW  (NW),
      .IDX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .n_i     (n),
      .mask_i  (mask),
      .top_i   (top),
      .valid_i (valid_c[k]),
      .ready_o (ready_c[k]),
      .a_i     (a_c[k]),
      .q_i     (q_c[k]),
      .qp_i    (qp_c[k]),
      .m_i     (m_c[k]),
      .valid_o (valid_c[k+1]),
      .ready_i (ready_c[k+1]),
      .a_o     (a_c[k+1]),
      .q_o     (q_c[k+1]),
      .qp_o    (qp_c[k+1]),
      .m_o     (m_c[k+1])
    );
  end

  // assemble A:Q over 2n bits and sign-extend from bit 2n-1
  logic [2*W-1:0]        pr, mask2, pr_ext;
  logic                  sign;
  logic signed [OUT_W-1:0] product_d, product_q;
  logic                  out_valid_q;

  assign pr     = ({{W{1'b0}}, a_c[W]} << n) | {{W{1'b0}}, q_c[W]};
  assign mask2  = ((2*W)'(1) << {n, 1'b0}) - (2*W)'(1);
  // top marks bit n-1 of A, the sign of the 2n-bit product
  assign sign   = |(a_c[W] & top);
  assign pr_ext = sign ? (pr | ~mask2) : pr;
  assign product_d = OUT_W'($signed(pr_ext));

  // output register: load when empty or the word is taken
  assign ready_c[W] = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready_c[W]) begin
      out_valid_q <= valid_c[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_c[W] && valid_c[W]) begin
      product_q <= product_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign product_o   = product_q;

endmodule

// ===== hw/rtl/booth_cell.sv =====
// One Booth recoding step with its own pipeline register and handshake.
module booth_cell
  import booth_pkg::*;
#(
  parameter int unsigned W   = 8,
  parameter int unsigned NW  = 4,
  parameter int unsigned IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [NW-1:0] n_i,
  input  logic [W-1:0]  mask_i,
  input  logic [W-1:0]  top_i,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [W-1:0]  a_i,
  input  logic [W-1:0]  q_i,
  input  logic          qp_i,
  input  logic [W-1:0]  m_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [W-1:0]  a_o,
  output logic [W-1:0]  q_o,
  output logic          qp_o,
  output logic [W-1:0]  m_o
);

  logic          valid_q;
  logic [W-1:0]  a_q, a_d, q_q, q_d, m_q;
  logic          qp_q, qp_d;
  logic [W-1:0]  neg_m, sum;
  logic          step_en;

  assign step_en = (NW'(IDX) < n_i);
  assign neg_m   = (~m_i + W'(1)) & mask_i;

  always_comb begin
    case ({q_i[0], qp_i})
      2'b10:   sum = (a_i + neg_m) & mask_i;
      2'b01:   sum = (a_i + m_i) & mask_i;
      default: sum = a_i;
    endcase
    if (step_en) begin
      // shift A:Q:Q-1 right arithmetically as one register
      a_d  = (sum >> 1) | (sum & top_i);
      q_d  = (q_i >> 1) | (sum[0] ? top_i : '0);
      qp_d = q_i[0];
    end else begin
      a_d  = a_i;
      q_d  = q_i;
      qp_d = qp_i;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      a_q  <= a_d;
      q_q  <= q_d;
      qp_q <= qp_d;
      m_q  <= m_i;
    end
  end

  assign valid_o = valid_q;
  assign a_o     = a_q;
  assign q_o     = q_q;
  assign qp_o    = qp_q;
  assign m_o     = m_q;

endmodule

// ===== hw/rtl/booth_chk.sv =====
// Port-level checker for the Booth multiplier, bound to the top level.
module booth_chk
  import booth_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    cfg_we_i,
  input logic [CFG_W-1:0]        cfg_wdata_i,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic signed [IN_W-1:0]  multiplicand_i,
  input logic signed [IN_W-1:0]  multiplier_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [OUT_W-1:0] product_o
);

  // no word leaves while reset is held
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // a free output side lets the whole chain move, so the input never stalls
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) |-> !in_stall_o)
    else $error("input stalled while output side is free");

  // hold a stalled word
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped under stall");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(product_o))
    else $error("output word changed under stall");

endmodule

bind booth_radix2_multiplier booth_chk u_booth_chk (.*);
